@@ src/knn_pkg.sv @@
// Types, constants and helpers shared by the k-nearest-neighbor classifier.
// No dependencies; every other file in src imports this package.
package knn_pkg;

	localparam int MAX_SAMPLES   = 32;
	localparam int NUM_FEATURES  = 4;
	localparam int NUM_NEIGHBORS = 3;
	localparam int NUM_CLASSES   = 3;
	localparam int FEATURE_BITS  = 16;

	localparam int IDX_W   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
	localparam int STEP_W  = $clog2(NUM_FEATURES + 1);
	localparam int FSEL_W  = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
	localparam int SQ_W    = 2 * FEATURE_BITS;
	localparam int DIST_W  = SQ_W + $clog2(NUM_FEATURES);
	localparam int CLASS_W = 2;
	localparam int VOTE_W  = $clog2(NUM_NEIGHBORS + 1);
	localparam int STAT_W  = 2;
	localparam int ACT_W   = 2;

	// Request action codes
	localparam logic [ACT_W-1:0] ACT_CLEAR    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_LOAD     = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLASSIFY = 2'd2;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_PRED = 2'd2;

	typedef logic [NUM_FEATURES-1:0][FEATURE_BITS-1:0] feat_vec_t;

	typedef struct packed {
		logic [ACT_W-1:0]        action;
		logic [FEATURE_BITS-1:0] feature_0;
		logic [FEATURE_BITS-1:0] feature_1;
		logic [FEATURE_BITS-1:0] feature_2;
		logic [FEATURE_BITS-1:0] feature_3;
		logic [CLASS_W-1:0]      class_label;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [CLASS_W-1:0] predicted_class;
		logic [VOTE_W-1:0]  winning_votes;
		logic [DIST_W-1:0]  nearest_distance;
	} res_t;

	typedef struct packed {
		logic [CLASS_W-1:0] label;
		feat_vec_t          feats;
	} sample_t;

	typedef struct packed {
		logic            en;
		logic [IDX_W-1:0] addr;
		sample_t         data;
	} store_wr_t;

	typedef struct packed {
		logic init;
		logic ins;
	} nbr_ctl_t;

	typedef struct packed {
		logic [CLASS_W-1:0] pred;
		logic [VOTE_W-1:0]  votes;
		logic [DIST_W-1:0]  nearest;
	} vote_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_SCAN,
		S_VOTE
	} state_t;

	function automatic feat_vec_t pack_features(input req_t r);
		feat_vec_t v;
		v[0] = r.feature_0;
		v[1] = r.feature_1;
		v[2] = r.feature_2;
		v[3] = r.feature_3;
		return v;
	endfunction

endpackage

@@ src/knn_store.sv @@
// Training sample memory: one write port, one registered read port.
// Depends on knn_pkg.
module knn_store (
	input  logic                    clk,
	input  knn_pkg::store_wr_t      wr,
	input  logic                    rd_en,
	input  logic [knn_pkg::IDX_W-1:0] rd_addr,
	output knn_pkg::sample_t        rd_data
);
	import knn_pkg::*;

	sample_t mem [MAX_SAMPLES];
	sample_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/knn_sqacc.sv @@
// Shared squared-difference unit with accumulator: one feature per cycle.
// Depends on knn_pkg.
module knn_sqacc (
	input  logic                          clk,
	input  logic [knn_pkg::FEATURE_BITS-1:0] a,
	input  logic [knn_pkg::FEATURE_BITS-1:0] b,
	input  logic                          clr,
	output logic [knn_pkg::DIST_W-1:0]    sum
);
	import knn_pkg::*;

	logic [FEATURE_BITS-1:0] diff;
	logic [SQ_W-1:0]         sq_s1;
	logic [DIST_W-1:0]       acc_q;

	assign diff = (a > b) ? (a - b) : (b - a);

	always_ff @(posedge clk) begin
		sq_s1 <= SQ_W'(diff) * SQ_W'(diff);
		acc_q <= clr ? '0 : (acc_q + DIST_W'(sq_s1));
	end

	// acc_q lags one product behind; fold in the last one
	assign sum = acc_q + DIST_W'(sq_s1);

endmodule

@@ src/knn_nbr.sv @@
// Sorted nearest-neighbor list with insertion and majority vote.
// Depends on knn_pkg.
module knn_nbr (
	input  logic                        clk,
	input  logic                        arst_n,
	input  knn_pkg::nbr_ctl_t           ctl,
	input  logic [knn_pkg::DIST_W-1:0]  distance,
	input  logic [knn_pkg::CLASS_W-1:0] label,
	output knn_pkg::vote_t              vote
);
	import knn_pkg::*;

	logic [DIST_W-1:0]  nd_q [NUM_NEIGHBORS];
	logic [CLASS_W-1:0] nl_q [NUM_NEIGHBORS];
	logic               nv_q [NUM_NEIGHBORS];

	logic [DIST_W-1:0]  prev_d [NUM_NEIGHBORS];
	logic [CLASS_W-1:0] prev_l [NUM_NEIGHBORS];
	logic               prev_v [NUM_NEIGHBORS];
	logic [NUM_NEIGHBORS-1:0] cand;
	logic [NUM_NEIGHBORS-1:0] take;

	logic [VOTE_W-1:0]  votes [NUM_CLASSES];
	logic [CLASS_W-1:0] best;
	logic [VOTE_W-1:0]  best_v;

	// List stays sorted with valid entries first, so cand is a suffix mask
	for (genvar s = 0; s < NUM_NEIGHBORS; s++) begin : g_slot
		assign cand[s] = !nv_q[s] || (distance < nd_q[s]);
		if (s == 0) begin : g_head
			assign take[s]   = cand[s];
			assign prev_d[s] = distance;
			assign prev_l[s] = label;
			assign prev_v[s] = 1'b1;
		end else begin : g_tail
			assign take[s]   = cand[s] && !cand[s-1];
			assign prev_d[s] = nd_q[s-1];
			assign prev_l[s] = nl_q[s-1];
			assign prev_v[s] = nv_q[s-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_NEIGHBORS; s++) nv_q[s] <= 1'b0;
		end else if (ctl.init) begin
			for (int s = 0; s < NUM_NEIGHBORS; s++) nv_q[s] <= 1'b0;
		end else if (ctl.ins) begin
			// the slot taking the new sample fills; a shifted slot inherits its neighbor's flag
			for (int s = 0; s < NUM_NEIGHBORS; s++) begin
				if (cand[s]) nv_q[s] <= take[s] | prev_v[s];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			for (int s = 0; s < NUM_NEIGHBORS; s++) begin
				if (take[s]) begin
					nd_q[s] <= distance;
					nl_q[s] <= label;
				end else if (cand[s]) begin
					nd_q[s] <= prev_d[s];
					nl_q[s] <= prev_l[s];
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CLASSES; c++) begin
			votes[c] = '0;
			for (int s = 0; s < NUM_NEIGHBORS; s++) begin
				if (nv_q[s] && nl_q[s] == CLASS_W'(c)) votes[c] = votes[c] + VOTE_W'(1);
			end
		end
		best   = '0;
		best_v = votes[0];
		// strict compare keeps the lowest class on ties
		for (int c = 1; c < NUM_CLASSES; c++) begin
			if (votes[c] > best_v) begin
				best   = CLASS_W'(c);
				best_v = votes[c];
			end
		end
	end

	assign vote.pred    = best;
	assign vote.votes   = best_v;
	assign vote.nearest = nv_q[0] ? nd_q[0] : '0;

endmodule

@@ src/knn_classifier.sv @@
// k-nearest-neighbor classifier (k = 3) top level: sequencer, request and result ports.
// Depends on knn_pkg, knn_store, knn_sqacc and knn_nbr.
//
//   channel  | signals                   | payload
//   ---------+---------------------------+---------------------------------------
//   request  | req_valid in, req_stall out | req: action, features, class_label
//   result   | res_valid out, res_stall in | res: status, class, votes, distance
//
// Clear, load and the unused action load the result register directly on accept.
// Classify fetches the first stored sample, then scans the samples in turn: the single
// squarer handles one feature per cycle, and a final step per sample does the last add
// and list insert; a classify on an empty store is answered directly from idle.
// Reset clears the sample count, the sequencer and the result valid; memory is not cleared.
// A request is taken only when idle and the result register is free or draining.
module knn_classifier (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  knn_pkg::req_t  req,
	output logic           res_valid,
	input  logic           res_stall,
	output knn_pkg::res_t  res
);
	import knn_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  idx_q;
	logic [STEP_W-1:0] step_q;
	feat_vec_t         query_q;

	logic  res_valid_q;
	res_t  res_q;
	res_t  res_d;
	logic  res_load;
	logic  res_free;

	logic  req_acc;
	logic  cnt_clr, cnt_inc, scan_start, step_adv, next_sample;
	logic  last_sample;

	store_wr_t        wr;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	sample_t          rd_data;

	logic              acc_clr;
	logic [FSEL_W-1:0] fsel;
	logic [DIST_W-1:0] distance;

	nbr_ctl_t nb_ctl;
	vote_t    vote;

	assign res_free    = !res_valid_q || !res_stall;
	assign req_acc     = req_valid && !req_stall;
	assign last_sample = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
	assign fsel        = step_q[FSEL_W-1:0];

	knn_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	knn_sqacc u_sqacc (
		.clk (clk),
		.a   (rd_data.feats[fsel]),
		.b   (query_q[fsel]),
		.clr (acc_clr),
		.sum (distance)
	);

	knn_nbr u_nbr (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (nb_ctl),
		.distance (distance),
		.label    (rd_data.label),
		.vote     (vote)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		req_stall   = 1'b1;
		wr.en       = 1'b0;
		wr.addr     = count_q[IDX_W-1:0];
		wr.data     = '{label: req.class_label, feats: pack_features(req)};
		rd_en       = 1'b0;
		rd_addr     = idx_q;
		acc_clr     = 1'b0;
		nb_ctl      = '0;
		res_load    = 1'b0;
		res_d       = '0;
		cnt_clr     = 1'b0;
		cnt_inc     = 1'b0;
		scan_start  = 1'b0;
		step_adv    = 1'b0;
		next_sample = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_stall = !res_free;
				if (req_valid && res_free) begin
					unique case (req.action)
						ACT_CLEAR: begin
							cnt_clr      = 1'b1;
							res_load     = 1'b1;
							res_d.status = STAT_DONE;
						end
						ACT_LOAD: begin
							res_load = 1'b1;
							if (count_q >= CNT_W'(MAX_SAMPLES)) begin
								res_d.status = STAT_FULL;
							end else begin
								wr.en        = 1'b1;
								cnt_inc      = 1'b1;
								res_d.status = STAT_DONE;
							end
						end
						ACT_CLASSIFY: begin
							if (count_q == '0) begin
								res_load     = 1'b1;
								res_d.status = STAT_PRED;
							end else begin
								scan_start  = 1'b1;
								nb_ctl.init = 1'b1;
								state_d     = S_FETCH;
							end
						end
						default: begin
							res_load     = 1'b1;
							res_d.status = STAT_DONE;
						end
					endcase
				end
			end
			S_FETCH: begin
				rd_en   = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				acc_clr = (step_q == '0);
				if (step_q == STEP_W'(NUM_FEATURES)) begin
					nb_ctl.ins = 1'b1;
					if (last_sample) begin
						state_d = S_VOTE;
					end else begin
						// prefetch the next sample while inserting this one
						rd_en       = 1'b1;
						rd_addr     = idx_q + IDX_W'(1);
						next_sample = 1'b1;
					end
				end else begin
					step_adv = 1'b1;
				end
			end
			S_VOTE: begin
				if (res_free) begin
					res_load               = 1'b1;
					res_d.status           = STAT_PRED;
					res_d.predicted_class  = vote.pred;
					res_d.winning_votes    = vote.votes;
					res_d.nearest_distance = vote.nearest;
					state_d                = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cnt_clr) begin
			count_q <= '0;
		end else if (cnt_inc) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			step_q <= '0;
		end else if (scan_start) begin
			idx_q  <= '0;
			step_q <= '0;
		end else if (next_sample) begin
			idx_q  <= idx_q + IDX_W'(1);
			step_q <= '0;
		end else if (step_adv) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (scan_start) begin
			query_q <= pack_features(req);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SAMPLES))
		else $error("sample count above store depth");

	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> CNT_W'(idx_q) < count_q)
		else $error("scan index past stored samples");

	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_IDLE || state_q == S_VOTE))
		else $error("result raised outside idle or vote");

	a_classify_start: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.action == ACT_CLASSIFY && count_q != '0) |=> state_q == S_FETCH)
		else $error("classify request did not start a scan");

endmodule
